FILE: design/npvt_pkg.sv
`default_nettype none
package npvt_pkg;
   localparam int COMP_W  = 16;
   localparam int ROW_W   = 48;
   localparam int LANES   = 3;
   localparam int IDX_W   = 2;
   localparam int PROD_W  = 32;
   localparam int PSUM_W  = 34;
   localparam int MAG_W   = 32;
   localparam int NIN_W   = 32;
   localparam int MSQ_W   = 64;
   localparam int NOUT_W  = 66;
   localparam int WIDE_W  = 104;
   localparam int Q_W     = 16;

   localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
   localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
   localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;

   localparam logic [ROW_W-1:0] ROW0_RESET = 48'h2000_0000_0000;
   localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_2000_0000;
   localparam logic [ROW_W-1:0] ROW2_RESET = 48'h0000_0000_2000;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
endpackage
`default_nettype wire

FILE: design/norm_preserving_vector_transform_top.sv
// Pipeline: request accept to rsp_valid runs through the 16 square-root search
// stages (one result bit per stage) plus 7 product, norm, seed and output stages.
// Throughput: one request per cycle; the whole pipeline holds while an output
// waits under rsp_stall.
// Reset: synchronous, clears all valid bits and loads the x/z swap matrix.
`default_nettype none
module norm_preserving_vector_transform_top (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire npvt_pkg::comp_type  req_dir_x,
   input  wire npvt_pkg::comp_type  req_dir_y,
   input  wire npvt_pkg::comp_type  req_dir_z,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output npvt_pkg::comp_type       rsp_out_x,
   output npvt_pkg::comp_type       rsp_out_y,
   output npvt_pkg::comp_type       rsp_out_z,
   output logic                     rsp_degenerate,
   output logic                     rsp_saturated,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire npvt_pkg::idx_type   csr_index,
   input  wire npvt_pkg::row_type   csr_data
);
   import npvt_pkg::*;

   localparam int STEPS = Q_W;

   logic    en;
   row_type row_ff [LANES];

   // stage 1
   logic                      v1_ff;
   logic signed [PROD_W-1:0]  prod_ff [LANES][LANES];
   logic [PROD_W-1:0]         sq_ff [LANES];
   // stage 2
   logic                      v2_ff;
   logic signed [PSUM_W-1:0]  psum_ff [LANES];
   logic [NIN_W-1:0]          nin2_ff;
   // stage 3
   logic                      v3_ff;
   logic [MAG_W-1:0]          mag_ff [LANES];
   logic [LANES-1:0]          neg3_ff;
   logic                      any3_ff;
   logic [NIN_W-1:0]          nin3_ff;
   // stage 4
   logic                      v4_ff;
   logic [MSQ_W-1:0]          msq_ff [LANES];
   logic [LANES-1:0]          neg4_ff;
   logic                      any4_ff;
   logic [NIN_W-1:0]          nin4_ff;
   // stage 5
   logic                      v5_ff;
   logic [NOUT_W-1:0]         nout5_ff;
   logic [MSQ_W-1:0]          tlo_ff [LANES];
   logic [MSQ_W-1:0]          thi_ff [LANES];
   logic [LANES-1:0]          neg5_ff;
   logic                      any5_ff;
   // search pipe, index 0 is the seed stage
   logic                      sv_ff   [STEPS+1];
   wide_type                  sn_ff   [STEPS+1];
   wide_type                  st_ff   [STEPS+1][LANES];
   wide_type                  sa_ff   [STEPS+1][LANES];
   wide_type                  sb_ff   [STEPS+1][LANES];
   logic [Q_W-1:0]            sq_q_ff [STEPS+1][LANES];
   logic [LANES-1:0]          sneg_ff [STEPS+1];
   logic                      sany_ff [STEPS+1];
   // output
   logic                      rsp_valid_ff;
   comp_type                  out_ff [LANES];
   logic                      degen_ff;
   logic                      sat_ff;

   comp_type dir [LANES];
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW0_RESET;
         row_ff[1] <= ROW1_RESET;
         row_ff[2] <= ROW2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROW0: row_ff[0] <= csr_data;
            REG_ROW1: row_ff[1] <= csr_data;
            REG_ROW2: row_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         rsp_valid_ff <= sv_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) sv_ff[s] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v5_ff;
         for (int s = 1; s <= STEPS; s++) sv_ff[s] <= sv_ff[s-1];
      end
   end

   // products and input squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) begin
            for (int k = 0; k < LANES; k++) begin
               prod_ff[j][k] <= $signed(row_ff[j][COMP_W*k +: COMP_W]) * dir[k];
            end
            sq_ff[j] <= PROD_W'($signed(dir[j]) * $signed(dir[j]));
         end
      end
   end

   // row sums and input norm
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) begin
            psum_ff[j] <= PSUM_W'(prod_ff[j][0]) + PSUM_W'(prod_ff[j][1])
                        + PSUM_W'(prod_ff[j][2]);
         end
         nin2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) begin
            mag_ff[j]  <= psum_ff[j][PSUM_W-1] ? MAG_W'(-psum_ff[j]) : MAG_W'(psum_ff[j]);
            neg3_ff[j] <= psum_ff[j][PSUM_W-1];
         end
         any3_ff <= (psum_ff[0] != '0) || (psum_ff[1] != '0) || (psum_ff[2] != '0);
         nin3_ff <= nin2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) msq_ff[j] <= mag_ff[j] * mag_ff[j];
         neg4_ff <= neg3_ff;
         any4_ff <= any3_ff;
         nin4_ff <= nin3_ff;
      end
   end

   // output norm and split target products
   always_ff @(posedge clock) begin
      if (en) begin
         nout5_ff <= NOUT_W'(msq_ff[0]) + NOUT_W'(msq_ff[1]) + NOUT_W'(msq_ff[2]);
         for (int j = 0; j < LANES; j++) begin
            tlo_ff[j] <= msq_ff[j][31:0] * nin4_ff;
            thi_ff[j] <= msq_ff[j][63:32] * nin4_ff;
         end
         neg5_ff <= neg4_ff;
         any5_ff <= any4_ff;
      end
   end

   // seed: target = 4 * P^2 * Nin, s = -1 so A = -Nout and B = Nout
   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff[0] <= WIDE_W'(nout5_ff);
         for (int j = 0; j < LANES; j++) begin
            st_ff[0][j]   <= ((WIDE_W'(thi_ff[j]) <<< 32) + WIDE_W'(tlo_ff[j])) <<< 2;
            sa_ff[0][j]   <= -WIDE_W'(nout5_ff);
            sb_ff[0][j]   <= WIDE_W'(nout5_ff);
            sq_q_ff[0][j] <= '0;
         end
         sneg_ff[0] <= neg5_ff;
         sany_ff[0] <= any5_ff;
      end
   end

   // one result bit per stage: try q + 2^b, keep it if (2q-1)^2 * Nout <= target
   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      localparam int BIT = STEPS - s;
      for (genvar j = 0; j < LANES; j++) begin : g_lane
         wide_type trial;
         logic     keep;
         assign trial = sb_ff[s-1][j] + (sa_ff[s-1][j] <<< (BIT + 2))
                      + (sn_ff[s-1] <<< (2*BIT + 2));
         assign keep  = (trial <= st_ff[s-1][j]);
         always_ff @(posedge clock) begin
            if (en) begin
               st_ff[s][j]   <= st_ff[s-1][j];
               sb_ff[s][j]   <= keep ? trial : sb_ff[s-1][j];
               sa_ff[s][j]   <= keep ? sa_ff[s-1][j] + (sn_ff[s-1] <<< (BIT + 1))
                                     : sa_ff[s-1][j];
               sq_q_ff[s][j] <= sq_q_ff[s-1][j] | (Q_W'(keep) << BIT);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sn_ff[s]   <= sn_ff[s-1];
            sneg_ff[s] <= sneg_ff[s-1];
            sany_ff[s] <= sany_ff[s-1];
         end
      end
   end

   // sign, clip, zero-product override
   logic [Q_W:0]     qmag [LANES];
   logic [LANES-1:0] clip;
   comp_type         res  [LANES];
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         qmag[j] = {1'b0, sq_q_ff[STEPS][j]};
         if (sneg_ff[STEPS][j]) begin
            clip[j] = qmag[j] > 17'd32768;
            res[j]  = clip[j] ? comp_type'(16'sh8000) : comp_type'(-qmag[j]);
         end else begin
            clip[j] = qmag[j] > 17'd32767;
            res[j]  = clip[j] ? comp_type'(16'sh7fff) : comp_type'(qmag[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) out_ff[j] <= sany_ff[STEPS] ? res[j] : '0;
         degen_ff <= !sany_ff[STEPS];
         sat_ff   <= sany_ff[STEPS] && (clip != '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;
endmodule
`default_nettype wire

FILE: tb/norm_preserving_vector_transform_checker.sv
`timescale 1ns / 1ps
module norm_preserving_vector_transform_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  npvt_pkg::comp_type  req_dir_x,
   input  npvt_pkg::comp_type  req_dir_y,
   input  npvt_pkg::comp_type  req_dir_z,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  npvt_pkg::comp_type  rsp_out_x,
   input  npvt_pkg::comp_type  rsp_out_y,
   input  npvt_pkg::comp_type  rsp_out_z,
   input  wire                 rsp_degenerate,
   input  wire                 rsp_saturated,
   input  wire                 csr_valid,
   input  wire                 csr_ready,
   input  npvt_pkg::idx_type   csr_index,
   input  npvt_pkg::row_type   csr_data,
   output int                  mismatches,
   output int                  pending,
   output int                  degenerate_seen,
   output int                  saturated_seen
);
   import npvt_pkg::*;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     degenerate;
      logic     saturated;
   } reoriented_type;

   row_type        matrix [LANES];
   reoriented_type reoriented_q[$];

   // Rescale M*d back to |d|, rounding exactly by squared comparison.
   function automatic reoriented_type reorient(comp_type dx, comp_type dy, comp_type dz);
      reoriented_type res;
      longint      d [3];
      longint      p [3];
      longint      c;
      longint      dsq;
      logic [127:0] mag, nout, nin, tgt, trial, odd;
      int unsigned lo, hi, mid;
      logic        any;
      d[0] = dx;
      d[1] = dy;
      d[2] = dz;
      any  = 0;
      nout = 0;
      nin  = 0;
      res  = '0;
      for (int j = 0; j < 3; j++) begin
         p[j] = 0;
         for (int k = 0; k < 3; k++) begin
            c = comp_type'(matrix[j][16*k +: 16]);
            p[j] += c * d[k];
         end
         if (p[j] != 0) any = 1;
         mag  = (p[j] < 0) ? -p[j] : p[j];
         nout += mag * mag;
         dsq  = d[j] * d[j];
         nin  += dsq;
      end
      if (!any) begin
         res.degenerate = 1;
         return res;
      end
      for (int j = 0; j < 3; j++) begin
         mag = (p[j] < 0) ? -p[j] : p[j];
         tgt = mag * mag * nin * 4;
         lo  = 0;
         hi  = 65535;
         while (lo < hi) begin
            mid   = (lo + hi + 1) >> 1;
            odd   = 2 * mid - 1;
            trial = nout * odd * odd;
            if (trial <= tgt) lo = mid;
            else hi = mid - 1;
         end
         if (p[j] < 0) begin
            if (lo > 32768) begin
               lo = 32768;
               res.saturated = 1;
            end
            c = -longint'(lo);
         end else begin
            if (lo > 32767) begin
               lo = 32767;
               res.saturated = 1;
            end
            c = lo;
         end
         case (j)
            0: res.x = c[15:0];
            1: res.y = c[15:0];
            default: res.z = c[15:0];
         endcase
      end
      return res;
   endfunction

   assign pending = reoriented_q.size();

   always @(posedge clock) begin
      reoriented_type want;
      reoriented_type got;
      if (reset) begin
         matrix[0] <= ROW0_RESET;
         matrix[1] <= ROW1_RESET;
         matrix[2] <= ROW2_RESET;
         reoriented_q.delete();
         mismatches      <= 0;
         degenerate_seen <= 0;
         saturated_seen  <= 0;
      end else begin
         if (req_valid && !req_stall)
            reoriented_q.push_back(reorient(req_dir_x, req_dir_y, req_dir_z));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_degenerate, rsp_saturated};
            if (reoriented_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected response %h", $realtime, got);
               mismatches <= mismatches + 1;
            end else begin
               want = reoriented_q.pop_front();
               degenerate_seen <= degenerate_seen + want.degenerate;
               saturated_seen  <= saturated_seen + want.saturated;
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch x %0d/%0d y %0d/%0d z %0d/%0d deg %b/%b sat %b/%b",
                        $realtime, want.x, got.x, want.y, got.y, want.z, got.z,
                        want.degenerate, got.degenerate, want.saturated, got.saturated);
                  mismatches <= mismatches + 1;
               end
            end
         end
         // writes to an unused index are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROW0: matrix[0] <= csr_data;
               REG_ROW1: matrix[1] <= csr_data;
               REG_ROW2: matrix[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: tb/norm_preserving_vector_transform_top_test.sv
`timescale 1ns / 1ps
module norm_preserving_vector_transform_top_test;
   import npvt_pkg::*;

   localparam idx_type REG_UNUSED = 2'd3;
   localparam int      DRAIN      = 40;
   localparam int      STALL_LIMIT = 3000;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   comp_type req_dir_x, req_dir_y, req_dir_z;
   logic     rsp_valid;
   logic     rsp_stall;
   comp_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic     rsp_degenerate, rsp_saturated;
   logic     csr_valid;
   logic     csr_ready;
   idx_type  csr_index;
   row_type  csr_data;

   int  mismatches, pending, degenerate_seen, saturated_seen;
   int  requests_sent;
   int  quiet_count;
   bit  calm;

   norm_preserving_vector_transform_top dut (.*);

   norm_preserving_vector_transform_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver side: random stall bursts until the calm tail.
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count > STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send(comp_type x, comp_type y, comp_type z);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Keep valid high across back-to-back writes; drop it after the last one.
   task automatic write_row(idx_type idx, row_type data, bit last);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 0;
   endtask

   task automatic load_matrix(row_type r0, row_type r1, row_type r2, bit last = 1);
      write_row(REG_ROW0, r0, 0);
      write_row(REG_ROW1, r1, 0);
      write_row(REG_ROW2, r2, last);
   endtask

   function automatic comp_type rand_comp(bit narrow);
      if (narrow) return comp_type'($urandom_range(0, 255)) - 16'sd128;
      return comp_type'($urandom_range(0, 65535));
   endfunction

   function automatic row_type rand_row(bit narrow);
      return {rand_comp(narrow), rand_comp(narrow), rand_comp(narrow)};
   endfunction

   task automatic random_batch(int count);
      bit narrow;
      for (int i = 0; i < count; i++) begin
         narrow = ($urandom_range(0, 3) == 0);
         send(rand_comp(narrow), rand_comp(narrow), rand_comp(narrow));
         if (i == count / 2 && $urandom_range(0, 1) == 0) drain();
      end
   endtask

   initial begin
      comp_type edges [6] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh4000,
                              16'shC000, 16'sh0001};
      calm = 0;
      requests_sent = 0;
      reset = 1;
      req_valid = 0;
      req_dir_x = 0;
      req_dir_y = 0;
      req_dir_z = 0;
      csr_valid = 0;
      csr_index = REG_ROW0;
      csr_data  = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset matrix (x/z swap)
      send(0, 0, 0);
      for (int i = 0; i < 6; i++) send(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
      send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send(16'sh8000, 16'sh8000, 16'sh8000);
      send(16'sh4000, 0, 0);
      send(0, 16'sh4000, 0);
      send(0, 0, 16'shC000);
      send(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send(1, -1, 1);
      // pause until the pipeline is empty
      drain();
      random_batch(220);
      drain();

      // extreme coefficients
      load_matrix({3{16'sh7FFF}}, {3{16'sh8000}}, {16'sh7FFF, 16'sh8000, 16'sh0001}, 0);
      write_row(REG_UNUSED, '0, 1);
      send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send(16'sh8000, 16'sh8000, 16'sh8000);
      send(1, 0, 0);
      random_batch(200);
      drain();

      // zero matrix: every product degenerate
      load_matrix('0, '0, '0);
      send(16'sh7FFF, 16'sh8000, 1);
      random_batch(60);
      drain();

      // singular matrix: rows equal, some products vanish
      load_matrix(48'h0000_E000_2000, 48'h0000_E000_2000, '0);
      send(16'sh1000, 16'sh1000, 16'sh7FFF);
      random_batch(200);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         load_matrix(rand_row(phase == 1), rand_row(0), rand_row(phase == 2));
         random_batch(260);
         drain();
      end

      // tail without idling on either side
      calm = 1;
      load_matrix(rand_row(0), rand_row(0), rand_row(0));
      random_batch(250);
      drain();

      $display("Sent %0d vectors over eight matrix settings, incl. zero and extreme ones.",
               requests_sent);
      $display("Degenerate results: %0d, saturated results: %0d.",
               degenerate_seen, saturated_seen);
      if (mismatches == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
